@@ sv/dpec_pkg.sv @@
// Shared types, constants and fixed-point helpers for the envelope compressor.
package dpec_pkg;

  localparam int SAMPLE_W = 24;
  localparam int Q24_W    = 32;
  localparam int OP_W     = 33;
  localparam int ACC_W    = 2 * OP_W;

  localparam int GAIN_W   = 22;
  localparam int MAKEUP_W = 17;
  localparam int SMOOTH_W = 21;
  localparam int WEIGHT_W = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAKEUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SMOOTH = 2'd2;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 22'd65536;
  localparam logic [GAIN_W-1:0]   UNITY_GAIN = 22'd65536;
  localparam logic [MAKEUP_W-1:0] MAKEUP_RST = 17'd65536;
  localparam logic [SMOOTH_W-1:0] SMOOTH_RST = 21'd40265;

  localparam logic [WEIGHT_W-1:0]     ONE_Q24  = 25'd16777216;
  localparam logic signed [Q24_W-1:0] ONE_S32  = 32'sd16777216;
  localparam logic signed [Q24_W-1:0] Q24_MAX  = 32'sh7fffffff;
  localparam logic signed [Q24_W-1:0] Q24_MIN  = 32'sh80000000;
  localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh800000;

  // golden-ratio blend weights, Q0.24
  localparam logic signed [OP_W-1:0] GOLD_OLD_OP = 33'sd10368890;
  localparam logic signed [OP_W-1:0] GOLD_NEW_OP = 33'sd6408326;
  localparam logic signed [OP_W-1:0] ONE_OP      = 33'sd16777216;

  // reciprocal 2^48 / t; any t at or below 2^17 saturates
  localparam int RECIP_W   = 31;
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [RECIP_W-1:0]   DIV_SAT_LIM = 31'd131072;

  typedef enum logic [5:0] {
    ST_IDLE, ST_MX, ST_WX,
    ST_MBP0, ST_MBP1, ST_MBP2, ST_WBP, ST_MSQP, ST_WSQP,
    ST_MBN0, ST_MBN1, ST_MBN2, ST_WBN, ST_MSQN, ST_WSQN,
    ST_MTP0, ST_MTP1, ST_WTP, ST_MTN0, ST_MTN1, ST_WTN,
    ST_DIVGO, ST_DIVWAIT, ST_MSQR, ST_WSQR,
    ST_MC0, ST_MC1, ST_WC, ST_MT0, ST_MT1, ST_WT,
    ST_MY, ST_WY, ST_MO, ST_WO, ST_DONE
  } state_t;

  function automatic logic signed [Q24_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-Q24_W:0] hi;
    hi = v[ACC_W-1:Q24_W-1];
    if (&hi || ~|hi) return v[Q24_W-1:0];
    return v[ACC_W-1] ? Q24_MIN : Q24_MAX;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-SAMPLE_W:0] hi;
    hi = v[ACC_W-1:SAMPLE_W-1];
    if (&hi || ~|hi) return v[SAMPLE_W-1:0];
    return v[ACC_W-1] ? S24_MIN : S24_MAX;
  endfunction

  function automatic logic signed [Q24_W-1:0] neg_sat(input logic signed [Q24_W-1:0] v);
    if (v == Q24_MIN) return Q24_MAX;
    return -v;
  endfunction

  function automatic logic signed [OP_W-1:0] sx32(input logic signed [Q24_W-1:0] v);
    return {v[Q24_W-1], v};
  endfunction

endpackage

@@ sv/dpec_div.sv @@
// Restoring divider for the envelope reciprocal 2^48 / t, one quotient bit per cycle.
module dpec_div import dpec_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [Q24_W-1:0] divisor,
  output logic                    done,
  output logic [RECIP_W-1:0]      quotient
);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [RECIP_W-1:0]   rem_r, div_r, q_r;
  logic [RECIP_W:0]     trial;
  logic                 fits;
  logic                 sat_case;

  assign trial    = {rem_r, 1'b0};
  assign fits     = (trial >= {1'b0, div_r});
  assign sat_case = divisor[Q24_W-1] || (divisor[RECIP_W-1:0] <= DIV_SAT_LIM);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt  = !sat_case;
      done_nxt = sat_case;
    end else if (run_r && cnt_r == DIV_LAST) begin
      run_nxt  = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper partial remainder is 2^48 >> 31, already below t
      rem_r <= DIV_SAT_LIM;
      div_r <= divisor[RECIP_W-1:0];
      cnt_r <= '0;
      q_r   <= sat_case ? '1 : '0;
    end else if (run_r) begin
      rem_r <= fits ? RECIP_W'(trial - {1'b0, div_r}) : trial[RECIP_W-1:0];
      q_r   <= {q_r[RECIP_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ sv/dual_phase_envelope_compressor_core.sv @@
// Top level of the dual-phase envelope compressor: sequencer around one shared MAC.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, in_sample_in[23:0]    | in
//  result   | out_valid, out_stall, out_sample_out[23:0]| out
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Each sample runs through the sequencer steps on the single 33x33 multiplier and waits
// for the bit-serial divider; the input stays stalled until the sample is finished.
// When the reciprocal saturates the divider finishes at once; a bypassed sample (input
// gain at or below unity) goes straight to the output step.
// Reset is synchronous: all envelopes and control gains return to 1.0.
// A held out_stall keeps the sequencer in its last step until the output register frees.
module dual_phase_envelope_compressor_core import dpec_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]   gain_r;
  logic [MAKEUP_W-1:0] makeup_r;
  logic [SMOOTH_W-1:0] smooth_r;

  logic                    phase_r;
  logic signed [Q24_W-1:0] prev_r;
  logic signed [Q24_W-1:0] target_pos_r, target_neg_r;
  logic signed [Q24_W-1:0] ctrl_a_pos_r, ctrl_a_neg_r, ctrl_b_pos_r, ctrl_b_neg_r;

  logic signed [SAMPLE_W-1:0] s_r, res_r;
  logic signed [Q24_W-1:0]    x_r, xn_r, pn_r, tmp_r, sqp_r, sqn_r;
  logic                       xpos_r;
  logic [WEIGHT_W-1:0]        wpos_r, wneg_r;

  logic signed [ACC_W-1:0] acc_r, prod, sh12, sh20, sh24;
  logic signed [OP_W-1:0]  op_a, op_b;
  logic                    acc_clr, mac_en, div_start;

  logic                    out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic                    out_free;

  logic [WEIGHT_W-1:0]        hold;
  logic signed [Q24_W-1:0]    ctrl_sel, x_sat, lvl;
  logic [RECIP_W-1:0]         half;
  logic [WEIGHT_W-1:0]        weight;
  logic                       bypass;
  logic                       div_done;
  logic [RECIP_W-1:0]         recip;

  dpec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (xpos_r ? target_pos_r : target_neg_r),
    .done     (div_done),
    .quotient (recip)
  );

  assign hold     = ONE_Q24 - {4'b0, smooth_r};
  assign bypass   = (gain_r <= UNITY_GAIN);
  assign out_free = !out_valid_r || !out_stall;
  assign prod     = op_a * op_b;
  assign sh12     = acc_r >>> 12;
  assign sh20     = acc_r >>> 20;
  assign sh24     = acc_r >>> 24;
  assign x_sat    = sat32(sh12);

  // clamped blend level and its weight min(level/2, 1)
  always_comb begin
    lvl    = sat32(sh24);
    if (lvl[Q24_W-1]) lvl = '0;
    half   = lvl[Q24_W-1:1];
    weight = (half > {6'b0, ONE_Q24}) ? ONE_Q24 : half[WEIGHT_W-1:0];
  end

  always_comb begin
    unique case ({xpos_r, phase_r})
      2'b11:   ctrl_sel = ctrl_a_pos_r;
      2'b10:   ctrl_sel = ctrl_b_pos_r;
      2'b01:   ctrl_sel = ctrl_a_neg_r;
      default: ctrl_sel = ctrl_b_neg_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = bypass ? ST_DONE : ST_MX;
      ST_MX:      state_nxt = ST_WX;
      ST_WX:      state_nxt = ST_MBP0;
      ST_MBP0:    state_nxt = ST_MBP1;
      ST_MBP1:    state_nxt = ST_MBP2;
      ST_MBP2:    state_nxt = ST_WBP;
      ST_WBP:     state_nxt = ST_MSQP;
      ST_MSQP:    state_nxt = ST_WSQP;
      ST_WSQP:    state_nxt = ST_MBN0;
      ST_MBN0:    state_nxt = ST_MBN1;
      ST_MBN1:    state_nxt = ST_MBN2;
      ST_MBN2:    state_nxt = ST_WBN;
      ST_WBN:     state_nxt = ST_MSQN;
      ST_MSQN:    state_nxt = ST_WSQN;
      ST_WSQN:    state_nxt = ST_MTP0;
      ST_MTP0:    state_nxt = ST_MTP1;
      ST_MTP1:    state_nxt = ST_WTP;
      ST_WTP:     state_nxt = ST_MTN0;
      ST_MTN0:    state_nxt = ST_MTN1;
      ST_MTN1:    state_nxt = ST_WTN;
      ST_WTN:     state_nxt = ST_DIVGO;
      ST_DIVGO:   state_nxt = ST_DIVWAIT;
      ST_DIVWAIT: if (div_done) state_nxt = ST_MSQR;
      ST_MSQR:    state_nxt = ST_WSQR;
      ST_WSQR:    state_nxt = ST_MC0;
      ST_MC0:     state_nxt = ST_MC1;
      ST_MC1:     state_nxt = ST_WC;
      ST_WC:      state_nxt = ST_MT0;
      ST_MT0:     state_nxt = ST_MT1;
      ST_MT1:     state_nxt = ST_WT;
      ST_WT:      state_nxt = ST_MY;
      ST_MY:      state_nxt = ST_WY;
      ST_WY:      state_nxt = ST_MO;
      ST_MO:      state_nxt = ST_WO;
      ST_WO:      state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs: MAC operands and strobes
  always_comb begin
    op_a      = '0;
    op_b      = '0;
    acc_clr   = 1'b0;
    mac_en    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_MX: begin
        op_a = OP_W'(s_r); op_b = {11'b0, gain_r}; acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MBP0: begin
        op_a = sx32(x_r); op_b = GOLD_OLD_OP; acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MBP1: begin
        op_a = sx32(prev_r); op_b = GOLD_NEW_OP; mac_en = 1'b1;
      end
      ST_MBN0: begin
        op_a = sx32(xn_r); op_b = GOLD_OLD_OP; acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MBN1: begin
        op_a = sx32(pn_r); op_b = GOLD_NEW_OP; mac_en = 1'b1;
      end
      ST_MBP2, ST_MBN2: begin
        // adds 1.0 after the >>24
        op_a = ONE_OP; op_b = ONE_OP; mac_en = 1'b1;
      end
      ST_MSQP, ST_MSQN: begin
        op_a = sx32(tmp_r); op_b = sx32(tmp_r); acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MTP0: begin
        op_a = sx32(target_pos_r); op_b = {8'b0, hold}; acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MTP1: begin
        op_a = sx32(sqp_r); op_b = {12'b0, smooth_r}; mac_en = 1'b1;
      end
      ST_MTN0: begin
        op_a = sx32(target_neg_r); op_b = {8'b0, hold}; acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MTN1: begin
        op_a = sx32(sqn_r); op_b = {12'b0, smooth_r}; mac_en = 1'b1;
      end
      ST_DIVGO: div_start = 1'b1;
      ST_MSQR: begin
        op_a = {2'b0, recip}; op_b = {2'b0, recip}; acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MC0: begin
        op_a = sx32(ctrl_sel); op_b = {8'b0, hold}; acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MC1: begin
        op_a = sx32(tmp_r); op_b = {12'b0, smooth_r}; mac_en = 1'b1;
      end
      ST_MT0: begin
        op_a = sx32(phase_r ? ctrl_a_pos_r : ctrl_b_pos_r); op_b = {8'b0, wpos_r};
        acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MT1: begin
        op_a = sx32(phase_r ? ctrl_a_neg_r : ctrl_b_neg_r); op_b = {8'b0, wneg_r};
        mac_en = 1'b1;
      end
      ST_MY: begin
        op_a = sx32(x_r); op_b = sx32(tmp_r); acc_clr = 1'b1; mac_en = 1'b1;
      end
      ST_MO: begin
        op_a = sx32(tmp_r); op_b = {16'b0, makeup_r}; acc_clr = 1'b1; mac_en = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gain_r       <= GAIN_RST;
      makeup_r     <= MAKEUP_RST;
      smooth_r     <= SMOOTH_RST;
      phase_r      <= 1'b0;
      prev_r       <= '0;
      target_pos_r <= ONE_S32;
      target_neg_r <= ONE_S32;
      ctrl_a_pos_r <= ONE_S32;
      ctrl_a_neg_r <= ONE_S32;
      ctrl_b_pos_r <= ONE_S32;
      ctrl_b_neg_r <= ONE_S32;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_IDX_GAIN:   gain_r   <= cfg_data;
          CFG_IDX_MAKEUP: makeup_r <= cfg_data[MAKEUP_W-1:0];
          CFG_IDX_SMOOTH: smooth_r <= cfg_data[SMOOTH_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_WX:  phase_r      <= !phase_r;
        ST_WBP: prev_r       <= x_r;
        ST_WTP: target_pos_r <= sat32(sh24);
        ST_WTN: target_neg_r <= sat32(sh24);
        ST_WC: begin
          unique case ({xpos_r, phase_r})
            2'b11:   ctrl_a_pos_r <= sat32(sh24);
            2'b10:   ctrl_b_pos_r <= sat32(sh24);
            2'b01:   ctrl_a_neg_r <= sat32(sh24);
            default: ctrl_b_neg_r <= sat32(sh24);
          endcase
        end
        default: ;
      endcase
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                 out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (mac_en) acc_r <= (acc_clr ? '0 : acc_r) + prod;
    unique case (state_r)
      ST_IDLE: begin
        s_r   <= in_sample_in;
        res_r <= in_sample_in;
      end
      ST_WX: begin
        x_r    <= x_sat;
        xn_r   <= neg_sat(x_sat);
        pn_r   <= neg_sat(prev_r);
        xpos_r <= !x_sat[Q24_W-1] && (|x_sat);
      end
      ST_WBP: begin
        tmp_r  <= lvl;
        wpos_r <= weight;
      end
      ST_WBN: begin
        tmp_r  <= lvl;
        wneg_r <= weight;
      end
      ST_WSQP: sqp_r <= sat32(sh24);
      ST_WSQN: sqn_r <= sat32(sh24);
      ST_WSQR, ST_WT, ST_WY: tmp_r <= sat32(sh24);
      ST_WO:   res_r <= sat24(sh20);
      default: ;
    endcase
    if (state_r == ST_DONE && out_free) out_data_r <= res_r;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule

@@ sv/dpec_chk.sv @@
// Port-level checks on the compressor core, bound to the top level.
module dpec_chk import dpec_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] out_sample_out
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("result changed while stalled");

  // one sample in flight: input closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // a new result only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in flight");

  // no result in the cycle right after an input transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result rose too early after input transfer");

endmodule

bind dual_phase_envelope_compressor_core dpec_chk u_dpec_chk (.*);

@@ dv/dual_phase_envelope_compressor_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the dual-phase envelope compressor core.
module dual_phase_envelope_compressor_core_tb import dpec_pkg::*; ();

  localparam int CLK_HALF      = 6;
  localparam int RST_CYCLES    = 11;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 80;
  localparam int IDLE_PAD      = 8;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [GAIN_W-1:0]    GAIN_MAX      = 22'd2359296;
  localparam logic [GAIN_W-1:0]    GAIN_MID      = 22'd1179648;
  localparam logic [MAKEUP_W-1:0]  MAKEUP_MIN    = 17'd2172;
  localparam logic [SMOOTH_W-1:0]  SMOOTH_MAX    = 21'd1048576;
  localparam logic [CFG_DATA_W-1:0] DATA_ONES    = '1;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  in_sample_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_sample_out;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // predictor copy of the registers and the compressor state
  logic [GAIN_W-1:0]       gain_reg   = GAIN_RST;
  logic [MAKEUP_W-1:0]     makeup_reg = MAKEUP_RST;
  logic [SMOOTH_W-1:0]     smooth_reg = SMOOTH_RST;
  logic                    phase_odd  = 1'b0;
  logic signed [Q24_W-1:0] last_x     = '0;
  logic signed [Q24_W-1:0] lvl_pos    = ONE_S32;
  logic signed [Q24_W-1:0] lvl_neg    = ONE_S32;
  logic signed [Q24_W-1:0] gc_a_pos   = ONE_S32;
  logic signed [Q24_W-1:0] gc_a_neg   = ONE_S32;
  logic signed [Q24_W-1:0] gc_b_pos   = ONE_S32;
  logic signed [Q24_W-1:0] gc_b_neg   = ONE_S32;

  logic signed [SAMPLE_W-1:0] expected_samples[$];

  int   fail_cnt     = 0;
  int   samples_sent = 0;
  int   results_seen = 0;
  int   settings_cnt = 1;
  int   cycle_cnt    = 0;
  int   rx_burst     = 0;
  bit   tx_gaps      = 1'b1;
  logic rx_gaps      = 1'b1;
  logic rx_hold      = 1'b0;

  dual_phase_envelope_compressor_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [Q24_W-1:0] clip32(input longint v);
    if (v > longint'(Q24_MAX)) return Q24_MAX;
    if (v < longint'(Q24_MIN)) return Q24_MIN;
    return v[Q24_W-1:0];
  endfunction

  function automatic logic signed [Q24_W-1:0] negate_clip(input logic signed [Q24_W-1:0] v);
    return clip32(-longint'(v));
  endfunction

  function automatic logic signed [Q24_W-1:0] one_pole(input logic signed [Q24_W-1:0] prior,
                                                       input logic signed [Q24_W-1:0] goal);
    longint r;
    longint acc;
    r = longint'(smooth_reg);
    acc = longint'(prior) * (longint'(ONE_S32) - r) + longint'(goal) * r;
    return clip32(acc >>> 24);
  endfunction

  function automatic logic signed [Q24_W-1:0] inverse_square(input logic signed [Q24_W-1:0] t);
    longint recip;
    if (t <= 0) return Q24_MAX;
    recip = (longint'(1) << 48) / longint'(t);
    if (recip > longint'(Q24_MAX)) recip = longint'(Q24_MAX);
    return clip32((recip * recip) >>> 24);
  endfunction

  // golden-ratio blend of current and previous level, offset by one and clamped at zero
  function automatic logic signed [Q24_W-1:0] blend_square(
      input  logic signed [Q24_W-1:0] cur,
      input  logic signed [Q24_W-1:0] prior,
      output logic signed [Q24_W-1:0] weight);
    logic signed [Q24_W-1:0] l;
    logic signed [Q24_W-1:0] half;
    l = clip32(((longint'(cur) * longint'(GOLD_OLD_OP) +
                 longint'(prior) * longint'(GOLD_NEW_OP)) >>> 24) + longint'(ONE_S32));
    if (l < 0) l = '0;
    half = l >>> 1;
    weight = (half > ONE_S32) ? ONE_S32 : half;
    return clip32((longint'(l) * longint'(l)) >>> 24);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] compress_sample(
      input logic signed [SAMPLE_W-1:0] s);
    logic signed [Q24_W-1:0] x, xn, pn, sq_p, sq_n, w_p, w_n, c_p, c_n, tot, y;
    longint acc;
    longint o;
    if (gain_reg <= UNITY_GAIN) return s;
    phase_odd = ~phase_odd;
    x  = clip32((longint'(s) * longint'(gain_reg)) >>> 12);
    xn = negate_clip(x);
    pn = negate_clip(last_x);
    sq_p = blend_square(x, last_x, w_p);
    sq_n = blend_square(xn, pn, w_n);
    last_x = x;
    lvl_pos = one_pole(lvl_pos, sq_p);
    lvl_neg = one_pole(lvl_neg, sq_n);
    c_p = inverse_square(lvl_pos);
    c_n = inverse_square(lvl_neg);
    // zero counts as negative polarity
    if (x > 0) begin
      if (phase_odd) gc_a_pos = one_pole(gc_a_pos, c_p);
      else gc_b_pos = one_pole(gc_b_pos, c_p);
    end else begin
      if (phase_odd) gc_a_neg = one_pole(gc_a_neg, c_n);
      else gc_b_neg = one_pole(gc_b_neg, c_n);
    end
    if (phase_odd) begin
      acc = longint'(gc_a_pos) * longint'(w_p) + longint'(gc_a_neg) * longint'(w_n);
    end else begin
      acc = longint'(gc_b_pos) * longint'(w_p) + longint'(gc_b_neg) * longint'(w_n);
    end
    tot = clip32(acc >>> 24);
    y = clip32((longint'(x) * longint'(tot)) >>> 24);
    o = (longint'(y) * longint'(makeup_reg)) >>> 20;
    if (o > longint'(S24_MAX)) return S24_MAX;
    if (o < longint'(S24_MIN)) return S24_MIN;
    return o[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : result_check
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (expected_samples.size() == 0) begin
        $error("sample_out: no result pending, actual %0d", out_sample_out);
        fail_cnt++;
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_out !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, out_sample_out);
          fail_cnt++;
        end
      end
    end
  end

  // receiver pacing: random stall bursts plus an optional long hold
  always @(posedge clk) begin : rx_pacing
    if (rx_burst > 0) begin
      rx_burst = rx_burst - 1;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      rx_burst = $urandom_range(1, 17);
    end
    out_stall <= rx_hold || (rx_burst > 0);
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_samples.size());
      $display("dual_phase_envelope_compressor_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- transfers

  // valid stays high after a transfer; the next call or wait_idle changes it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    if (tx_gaps && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_samples.push_back(compress_sample(s));
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit hold_valid);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_IDX_GAIN:   gain_reg   = data[GAIN_W-1:0];
      CFG_IDX_MAKEUP: makeup_reg = data[MAKEUP_W-1:0];
      CFG_IDX_SMOOTH: smooth_reg = data[SMOOTH_W-1:0];
      default: ;
    endcase
    if (!hold_valid) cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] g, input logic [CFG_DATA_W-1:0] m,
                          input logic [CFG_DATA_W-1:0] r);
    write_reg(CFG_IDX_GAIN, g, 1'b1);
    write_reg(CFG_IDX_MAKEUP, m, 1'b1);
    write_reg(CFG_IDX_SMOOTH, r, 1'b0);
    settings_cnt++;
  endtask

  task automatic rand_regs();
    logic [CFG_DATA_W-1:0] g, m, r;
    case ($urandom_range(0, 9))
      0:       g = CFG_DATA_W'($urandom_range(0, UNITY_GAIN));
      1:       g = CFG_DATA_W'($urandom);
      default: g = CFG_DATA_W'($urandom_range(UNITY_GAIN + 1, GAIN_MAX));
    endcase
    if ($urandom_range(0, 7) == 0) m = CFG_DATA_W'($urandom);
    else m = CFG_DATA_W'($urandom_range(MAKEUP_MIN, MAKEUP_RST));
    case ($urandom_range(0, 9))
      0:       r = '0;
      1:       r = CFG_DATA_W'(1);
      2:       r = {{(CFG_DATA_W-SMOOTH_W){1'b0}}, {SMOOTH_W{1'b1}}};
      3:       r = CFG_DATA_W'($urandom);
      default: r = CFG_DATA_W'($urandom_range(1, SMOOTH_MAX));
    endcase
    if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom), 1'b1);
    set_regs(g, m, r);
  endtask

  // pol: 1 positive or zero, -1 negative, 0 either; magnitude on a random scale
  function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int pol);
    int bits;
    logic [SAMPLE_W-1:0] mag;
    if (pol == 0 && $urandom_range(0, 3) == 0) return SAMPLE_W'($urandom);
    if (pol == 0) pol = $urandom_range(0, 1) ? 1 : -1;
    if ($urandom_range(0, 9) == 0) begin
      mag = S24_MAX;
    end else begin
      bits = $urandom_range(1, SAMPLE_W - 1);
      mag  = SAMPLE_W'($urandom_range(0, (1 << bits) - 1));
    end
    return (pol > 0) ? mag : ~mag;
  endfunction

  // ---------------------------------------------------------------- tests

  // unity and sub-unity gain pass samples straight through
  task automatic test_bypass();
    logic signed [SAMPLE_W-1:0] pts [7] = '{'0, S24_MAX, S24_MIN, 24'sd1, -24'sd1,
                                            24'sh555555, 24'shAAAAAA};
    foreach (pts[i]) send_sample(pts[i]);
    wait_idle();
    set_regs('0, CFG_DATA_W'(MAKEUP_MIN), CFG_DATA_W'(1));
    send_sample(S24_MAX);
    send_sample(-24'sd4096);
    send_sample(S24_MIN);
    wait_idle();
  endtask

  task automatic test_extremes();
    logic signed [SAMPLE_W-1:0] hot [10] = '{'0, S24_MAX, S24_MIN, S24_MIN, S24_MAX,
                                             24'sd1, -24'sd1, '0, 24'sh100000, -24'sh100000};
    logic signed [SAMPLE_W-1:0] wide [5] = '{S24_MAX, S24_MIN, '0, 24'sh000800, -24'sh000800};
    set_regs(GAIN_MAX, CFG_DATA_W'(MAKEUP_RST), CFG_DATA_W'(SMOOTH_MAX));
    foreach (hot[i]) send_sample(hot[i]);
    wait_idle();
    // all-ones data: registers keep only their own width
    set_regs(DATA_ONES, DATA_ONES, DATA_ONES);
    foreach (wide[i]) send_sample(wide[i]);
    wait_idle();
    write_reg(CFG_IDX_SPARE, DATA_ONES, 1'b1);
    // zero smoothing freezes every envelope
    set_regs(CFG_DATA_W'(UNITY_GAIN + 1), CFG_DATA_W'(MAKEUP_MIN), '0);
    foreach (wide[i]) send_sample(wide[i]);
    wait_idle();
  endtask

  // long same-polarity runs drive one target to zero and the reciprocal into saturation
  task automatic test_target_decay();
    set_regs(GAIN_MAX, CFG_DATA_W'(MAKEUP_RST), CFG_DATA_W'({SMOOTH_W{1'b1}}));
    repeat (48) send_sample(-SAMPLE_W'($urandom_range(1 << 16, 1 << 23)));
    repeat (48) send_sample(SAMPLE_W'($urandom_range(1 << 16, (1 << 23) - 1)));
    wait_idle();
  endtask

  task automatic test_random_phases();
    int n, run, pol;
    for (int p = 0; p < 7; p++) begin
      rand_regs();
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps <= ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 60);
      while (n > 0) begin
        run = $urandom_range(1, 12);
        pol = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 3))
          0: repeat (run) send_sample(rand_sample(pol));
          1: repeat (run) begin
            send_sample(rand_sample(pol));
            pol = -pol;
          end
          default: begin
            run = 1;
            send_sample(rand_sample(0));
          end
        endcase
        n -= run;
      end
      wait_idle();
    end
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    set_regs(CFG_DATA_W'(GAIN_MID), CFG_DATA_W'(MAKEUP_RST), CFG_DATA_W'(SMOOTH_RST));
    tx_gaps = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        repeat (12) send_sample(rand_sample(0));
        wait_idle();
      end
    join
  endtask

  task automatic test_no_gaps();
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    set_regs(GAIN_MAX, CFG_DATA_W'(MAKEUP_RST), CFG_DATA_W'(SMOOTH_RST));
    repeat (40) send_sample(rand_sample(0));
    wait_idle();
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bypass();
    test_extremes();
    test_target_decay();
    test_random_phases();
    test_backpressure();
    test_no_gaps();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d samples sent, %0d results checked over %0d register settings",
             samples_sent, results_seen, settings_cnt);
    $display("covered bypass, full-scale and zero input, frozen and saturated envelopes, long hold");
    if (fail_cnt == 0 && expected_samples.size() == 0) begin
      $display("dual_phase_envelope_compressor_core: match");
    end else begin
      $display("dual_phase_envelope_compressor_core: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/dpec_pkg.sv
sv/dpec_div.sv
sv/dual_phase_envelope_compressor_core.sv
sv/dpec_chk.sv
dv/dual_phase_envelope_compressor_core_tb.sv
